// ===== sv/llfv_pkg.sv =====
// ----------------------------------------------------------------------------
// llfv_pkg
// shared types and constants of the log-law friction velocity solver
// ----------------------------------------------------------------------------
package llfv_pkg;

    localparam int LOG_FRAC  = 24;
    localparam int DIV_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 32;
    localparam int LG_W      = 29;

    localparam logic signed [31:0] LN2_Q30  = 32'sd744261118;
    localparam logic signed [63:0] FSAT     = 64'sd1073741824;
    localparam logic signed [63:0] STEP_SAT = 64'sd1099511627776;

    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KAPPA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VISC   = 2'd3;

    typedef struct packed {
        logic [27:0]        reference_height;
        logic [15:0]        von_karman_constant;
        logic signed [23:0] log_offset;
        logic [31:0]        kinematic_viscosity;
    } cfg_t;

    typedef struct packed {
        logic signed [20:0] surface_flux_in;
        logic [25:0]        surface_temp_in;
        logic [31:0]        wind_speed;
    } item_t;

    typedef struct packed {
        logic               converged;
        logic [4:0]         steps_taken;
        logic [25:0]        surface_temp_out;
        logic signed [20:0] surface_flux_out;
        logic [31:0]        friction_velocity;
    } result_t;

    typedef struct packed {
        logic        start;
        logic [31:0] value;
    } log_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [LG_W-1:0] result;
    } log_rsp_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [DIV_W-1:0] dividend;
        logic [31:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/llfv_front.sv =====
// ----------------------------------------------------------------------------
// llfv_front
// input side: accepts items into a two-entry queue toward the solver
// ----------------------------------------------------------------------------
module llfv_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  llfv_pkg::item_t s_item,
    output logic           q_valid,
    input  logic           q_ready,
    output llfv_pkg::item_t q_item
);
    import llfv_pkg::*;

    item_t      q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= s_item;
        end
    end

endmodule

// ===== sv/llfv_log2.sv =====
// ----------------------------------------------------------------------------
// llfv_log2
// iterative log2 of a positive integer, q.24, one squaring per cycle
// ----------------------------------------------------------------------------
module llfv_log2 (
    input  logic                aclk,
    input  logic                aresetn,
    input  llfv_pkg::log_req_t  req,
    output llfv_pkg::log_rsp_t  rsp
);
    import llfv_pkg::*;

    logic          busy_reg, done_reg;
    logic [4:0]    cnt_reg;
    logic [31:0]   m_reg;
    logic [4:0]    ip_reg;
    logic [23:0]   frac_reg;
    logic [4:0]    msb;
    logic [4:0]    shamt;
    logic [31:0]   norm;
    logic [63:0]   sq;
    logic [32:0]   sq_shr;

    always_comb begin
        msb = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (req.value[i]) begin
                msb = 5'(i);
            end
        end
        shamt  = 5'd31 - msb;
        norm   = req.value << shamt;
        sq     = m_reg * m_reg;
        sq_shr = sq[63:31];
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = {ip_reg, frac_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(LOG_FRAC);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            m_reg    <= norm;
            ip_reg   <= msb;
            frac_reg <= 24'd0;
        end else if (busy_reg) begin
            if (sq_shr[32]) begin
                m_reg    <= sq_shr[32:1];
                frac_reg <= {frac_reg[22:0], 1'b1};
            end else begin
                m_reg    <= sq_shr[31:0];
                frac_reg <= {frac_reg[22:0], 1'b0};
            end
        end
    end

endmodule

// ===== sv/llfv_div.sv =====
// ----------------------------------------------------------------------------
// llfv_div
// restoring signed divider, truncating, one quotient bit per cycle
// ----------------------------------------------------------------------------
module llfv_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  llfv_pkg::div_req_t  req,
    output llfv_pkg::div_rsp_t  rsp
);
    import llfv_pkg::*;

    logic             busy_reg, done_reg;
    logic [6:0]       cnt_reg;
    logic             neg_reg;
    logic [DIV_W-1:0] dq_reg;
    logic [31:0]      dvs_reg;
    logic [31:0]      rem_reg;
    logic [32:0]      rem_sh;
    logic [32:0]      rem_sub;
    logic             fits;

    always_comb begin
        rem_sh  = {rem_reg, dq_reg[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        fits    = (rem_sh >= {1'b0, dvs_reg});
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(dq_reg) : $signed(dq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dq_reg  <= req.dividend;
            dvs_reg <= req.divisor;
            neg_reg <= req.neg;
            rem_reg <= 32'd0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_sub[31:0];
                dq_reg  <= {dq_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[31:0];
                dq_reg  <= {dq_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== sv/llfv_back.sv =====
// ----------------------------------------------------------------------------
// llfv_back
// newton-raphson sequencer over shared log2 and divider, with output register
// ----------------------------------------------------------------------------
module llfv_back #(
    parameter int MAX_STEPS          = 20,
    parameter int VELOCITY_FRAC_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  llfv_pkg::cfg_t     cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  llfv_pkg::item_t    q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output llfv_pkg::result_t  m_res
);
    import llfv_pkg::*;

    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int SW = (CW > 5) ? CW : 5;
    localparam longint ONE_V = longint'(1) << VELOCITY_FRAC_BITS;
    localparam logic [31:0] START_U = 32'((ONE_V + 5) / 10);
    localparam logic signed [41:0] TOL = 42'((ONE_V + 50000) / 100000);
    localparam logic signed [31:0] SCALE_OFF =
        32'((VELOCITY_FRAC_BITS - 16) * (longint'(1) << LOG_FRAC));

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_LOGZ  = 13'b0000000000010,
        ST_LOGNU = 13'b0000000000100,
        ST_CHECK = 13'b0000000001000,
        ST_LOGU  = 13'b0000000010000,
        ST_LN    = 13'b0000000100000,
        ST_FPGO  = 13'b0000001000000,
        ST_DIVFP = 13'b0000010000000,
        ST_DIVF  = 13'b0000100000000,
        ST_MUL   = 13'b0001000000000,
        ST_STGO  = 13'b0010000000000,
        ST_DIVST = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [31:0]        u_reg, u_next;
    logic [31:0]        tgt_reg, tgt_next;
    logic [25:0]        temp_reg, temp_next;
    logic signed [20:0] flux_reg, flux_next;
    logic [CW-1:0]      steps_reg, steps_next;
    logic               conv_reg, conv_next;
    logic [LG_W-1:0]    lgz_reg, lgz_next;
    logic [LG_W-1:0]    lgnu_reg, lgnu_next;
    logic signed [31:0] l2_reg, l2_next;
    logic signed [31:0] lnx_reg, lnx_next;
    logic signed [31:0] fp_reg, fp_next;
    logic signed [31:0] f_reg, f_next;
    logic signed [41:0] num_reg, num_next;
    logic signed [41:0] step_reg, step_next;
    logic               m_valid_reg, m_valid_next;
    result_t            m_res_reg, m_res_next;

    log_req_t log_req;
    log_rsp_t log_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [15:0]        kap_eff;
    logic signed [31:0] b24;
    logic signed [63:0] ln_prod;
    logic signed [63:0] ln_round;
    logic signed [32:0] lnp1;
    logic [32:0]        lnp1_mag;
    logic [31:0]        lnx_mag;
    logic signed [63:0] fq_sum;
    logic signed [31:0] fq_sat;
    logic signed [64:0] p_prod;
    logic signed [64:0] p_round;
    logic [41:0]        num_mag;
    logic [31:0]        fp_mag;
    logic signed [42:0] u_new;
    logic [31:0]        u_sat;
    logic [SW-1:0]      steps_ext;
    logic               out_free;

    llfv_log2 u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (log_req),
        .rsp     (log_rsp)
    );

    llfv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        kap_eff  = (cfg.von_karman_constant == 16'd0) ? 16'd1 : cfg.von_karman_constant;
        b24      = {cfg.log_offset, 8'd0};
        ln_prod  = l2_reg * LN2_Q30;
        ln_round = (ln_prod + 64'sd536870912) >>> 30;
        lnp1     = {lnx_reg[31], lnx_reg} + 33'sd16777216;
        lnp1_mag = lnp1[32] ? 33'(-lnp1) : 33'(lnp1);
        lnx_mag  = lnx_reg[31] ? 32'(-lnx_reg) : 32'(lnx_reg);
        fq_sum   = div_rsp.quotient + 64'(b24);
        if (fq_sum > FSAT) begin
            fq_sat = 32'(FSAT);
        end else if (fq_sum < -FSAT) begin
            fq_sat = 32'(-FSAT);
        end else begin
            fq_sat = fq_sum[31:0];
        end
        p_prod   = $signed({1'b0, u_reg}) * f_reg;
        p_round  = (p_prod + 65'sd8388608) >>> 24;
        num_mag  = num_reg[41] ? 42'(-num_reg) : 42'(num_reg);
        fp_mag   = fp_reg[31] ? 32'(-fp_reg) : 32'(fp_reg);
        u_new    = $signed({11'd0, u_reg}) - 43'(step_reg);
        if (u_new < 43'sd0) begin
            u_sat = 32'd0;
        end else if (u_new > 43'sd4294967295) begin
            u_sat = 32'hFFFFFFFF;
        end else begin
            u_sat = u_new[31:0];
        end
        steps_ext = SW'(steps_reg);
        out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next   = state_reg;
        u_next       = u_reg;
        tgt_next     = tgt_reg;
        temp_next    = temp_reg;
        flux_next    = flux_reg;
        steps_next   = steps_reg;
        conv_next    = conv_reg;
        lgz_next     = lgz_reg;
        lgnu_next    = lgnu_reg;
        l2_next      = l2_reg;
        lnx_next     = lnx_reg;
        fp_next      = fp_reg;
        f_next       = f_reg;
        num_next     = num_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_res_next   = m_res_reg;
        q_ready      = 1'b0;
        log_req      = '0;
        div_req      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    tgt_next   = q_item.wind_speed;
                    temp_next  = q_item.surface_temp_in;
                    flux_next  = q_item.surface_flux_in;
                    u_next     = START_U;
                    steps_next = '0;
                    conv_next  = 1'b0;
                    if (cfg.reference_height == 28'd0 || cfg.kinematic_viscosity == 32'd0) begin
                        state_next = ST_OUT;
                    end else begin
                        log_req.start = 1'b1;
                        log_req.value = {4'd0, cfg.reference_height};
                        state_next    = ST_LOGZ;
                    end
                end
            end
            ST_LOGZ: begin
                if (log_rsp.done) begin
                    lgz_next      = log_rsp.result;
                    log_req.start = 1'b1;
                    log_req.value = cfg.kinematic_viscosity;
                    state_next    = ST_LOGNU;
                end
            end
            ST_LOGNU: begin
                if (log_rsp.done) begin
                    lgnu_next  = log_rsp.result;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (steps_reg >= CW'(MAX_STEPS) || u_reg == 32'd0) begin
                    state_next = ST_OUT;
                end else begin
                    log_req.start = 1'b1;
                    log_req.value = u_reg;
                    state_next    = ST_LOGU;
                end
            end
            ST_LOGU: begin
                if (log_rsp.done) begin
                    l2_next = $signed({3'd0, log_rsp.result}) + $signed({3'd0, lgz_reg})
                              - $signed({3'd0, lgnu_reg}) - SCALE_OFF;
                    state_next = ST_LN;
                end
            end
            ST_LN: begin
                lnx_next   = ln_round[31:0];
                state_next = ST_FPGO;
            end
            ST_FPGO: begin
                div_req.start    = 1'b1;
                div_req.neg      = lnp1[32];
                div_req.dividend = {15'd0, lnp1_mag, 16'd0};
                div_req.divisor  = {16'd0, kap_eff};
                state_next       = ST_DIVFP;
            end
            ST_DIVFP: begin
                if (div_rsp.done) begin
                    fp_next = fq_sat;
                    if (fq_sat == 32'sd0) begin
                        state_next = ST_OUT;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.neg      = lnx_reg[31];
                        div_req.dividend = {16'd0, lnx_mag, 16'd0};
                        div_req.divisor  = {16'd0, kap_eff};
                        state_next       = ST_DIVF;
                    end
                end
            end
            ST_DIVF: begin
                if (div_rsp.done) begin
                    f_next     = fq_sat;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                num_next   = p_round[41:0] - $signed({10'd0, tgt_reg});
                state_next = ST_STGO;
            end
            ST_STGO: begin
                div_req.start    = 1'b1;
                div_req.neg      = num_reg[41] ^ fp_reg[31];
                div_req.dividend = {num_mag[39:0], 24'd0};
                div_req.divisor  = fp_mag;
                state_next       = ST_DIVST;
            end
            ST_DIVST: begin
                // stays here for the update cycle, which picks the next state
                if (div_rsp.done) begin
                    if (div_rsp.quotient > STEP_SAT) begin
                        step_next = 42'(STEP_SAT);
                    end else if (div_rsp.quotient < -STEP_SAT) begin
                        step_next = 42'(-STEP_SAT);
                    end else begin
                        step_next = div_rsp.quotient[41:0];
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next                 = 1'b1;
                    m_res_next.friction_velocity = u_reg;
                    m_res_next.surface_flux_out  = flux_reg;
                    m_res_next.surface_temp_out  = temp_reg;
                    m_res_next.steps_taken       = steps_ext[4:0];
                    m_res_next.converged         = conv_reg;
                    state_next                   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // update of the iterate, in the cycle after the step quotient lands
    logic upd_reg;
    logic signed [41:0] step_abs_chk;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_reg <= 1'b0;
        end else begin
            upd_reg <= (state_reg == ST_DIVST) && div_rsp.done;
        end
    end

    assign step_abs_chk = step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            steps_reg   <= '0;
            conv_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (upd_reg) begin
                steps_reg <= steps_reg + CW'(1);
                if (step_abs_chk <= TOL && step_abs_chk >= -TOL) begin
                    conv_reg  <= 1'b1;
                    state_reg <= ST_OUT;
                end else begin
                    state_reg <= ST_CHECK;
                end
            end else begin
                state_reg <= state_next;
                steps_reg <= steps_next;
                conv_reg  <= conv_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        u_reg     <= upd_reg ? u_sat : u_next;
        tgt_reg   <= tgt_next;
        temp_reg  <= temp_next;
        flux_reg  <= flux_next;
        lgz_reg   <= lgz_next;
        lgnu_reg  <= lgnu_next;
        l2_reg    <= l2_next;
        lnx_reg   <= lnx_next;
        fp_reg    <= fp_next;
        f_reg     <= f_next;
        num_reg   <= num_next;
        step_reg  <= step_next;
        m_res_reg <= m_res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_reg <= CW'(MAX_STEPS))
        else $error("step count beyond limit");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_log_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        log_req.start |-> !log_rsp.busy)
        else $error("log2 unit started while busy");

    a_fp_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STGO) |-> (fp_reg != 32'sd0))
        else $error("step division with zero derivative");

endmodule

// ===== sv/log_law_friction_velocity_solver_core.sv =====
// ----------------------------------------------------------------------------
// log_law_friction_velocity_solver_core
// sequence: two log2 runs of setup (height, then viscosity), then per
// newton step one log2 run, three divisions and handoffs, with each item
// also passing through the input queue and the output register
// throughput: one item at a time through the shared log2 and divider units;
// a two-entry input queue and the output register let both sides stall apart
// reset: aresetn synchronous active low, clears control and loads register
// defaults; no clearing pass
// ----------------------------------------------------------------------------
module log_law_friction_velocity_solver_core #(
    parameter int MAX_STEPS          = 20,
    parameter int VELOCITY_FRAC_BITS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // wind_speed[31:0], surface_temp_in[57:32], surface_flux_in[78:58], zero pad
    input  logic [79:0]                        s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // friction_velocity[31:0], surface_flux_out[52:32], surface_temp_out[78:53],
    // steps_taken[83:79], converged[84], zero pad
    output logic [87:0]                        m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [llfv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [llfv_pkg::CFG_DW-1:0]        cfg_data
);
    import llfv_pkg::*;

    cfg_t    cfg_reg;
    item_t   s_item;
    item_t   q_item;
    logic    q_valid, q_ready;
    result_t m_res;

    assign s_item.wind_speed      = s_tdata[31:0];
    assign s_item.surface_temp_in = s_tdata[57:32];
    assign s_item.surface_flux_in = s_tdata[78:58];

    assign m_tdata = {3'd0, m_res.converged, m_res.steps_taken, m_res.surface_temp_out,
                      m_res.surface_flux_out, m_res.friction_velocity};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reference_height    <= 28'd327680;
            cfg_reg.von_karman_constant <= 16'd26214;
            cfg_reg.log_offset          <= 24'sd360448;
            cfg_reg.kinematic_viscosity <= 32'd64425;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HEIGHT: cfg_reg.reference_height    <= cfg_data[27:0];
                REG_KAPPA:  cfg_reg.von_karman_constant <= cfg_data[15:0];
                REG_OFFSET: cfg_reg.log_offset          <= cfg_data[23:0];
                REG_VISC:   cfg_reg.kinematic_viscosity <= cfg_data[31:0];
                default:    cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    llfv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    llfv_back #(
        .MAX_STEPS          (MAX_STEPS),
        .VELOCITY_FRAC_BITS (VELOCITY_FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

endmodule

// ===== bench/log_law_friction_velocity_solver_core_tb.sv =====
// ----------------------------------------------------------------------------
// log_law_friction_velocity_solver_core_tb
// self-checking bench: a newton-raphson predictor in fixed point computes the
// expected friction velocity, step count and convergence flag for every
// accepted input transaction; results are compared field by field in order
// ----------------------------------------------------------------------------
module log_law_friction_velocity_solver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import llfv_pkg::*;

    localparam int       VFRAC     = 24;
    localparam int       NSTEPS    = 20;
    localparam longint   CYC_LIMIT = 40_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DW-1:0]    cfg_data = '0;

    cfg_t    shadow_cfg;
    result_t expected_results[$];
    int      error_count = 0;
    longint  cycle_count = 0;
    bit      hold_off_req = 1'b0;

    log_law_friction_velocity_solver_core #(
        .MAX_STEPS(NSTEPS),
        .VELOCITY_FRAC_BITS(VFRAC)
    ) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint log2_fixed(longint unsigned v);
        int              msb;
        longint unsigned m;
        longint          fr;
        msb = 0;
        while (msb < 63 && (v >> (msb + 1)) != 0) msb++;
        m = (msb >= 31) ? (v >> (msb - 31)) : (v << (31 - msb));
        fr = 0;
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return longint'(msb) * (64'sd1 <<< LOG_FRAC) + fr;
    endfunction

    function automatic result_t solve_friction_velocity(item_t it);
        result_t r;
        longint  u, target, kap, b24, scale_off, tol;
        longint  l2, lnx, f, fp, p, num, stp;
        int      steps;
        bit      conv;
        tol = ((64'sd1 <<< VFRAC) + 50000) / 100000;
        u = ((64'sd1 <<< VFRAC) + 5) / 10;
        target = longint'({32'd0, it.wind_speed});
        kap = (shadow_cfg.von_karman_constant != 0) ?
              longint'({48'd0, shadow_cfg.von_karman_constant}) : 1;
        b24 = longint'(shadow_cfg.log_offset) * 256;
        scale_off = longint'(VFRAC + 16 - 32) * (64'sd1 <<< LOG_FRAC);
        steps = 0;
        conv = 1'b0;
        forever begin
            if (steps >= NSTEPS) break;
            if (u == 0 || shadow_cfg.reference_height == 0 ||
                shadow_cfg.kinematic_viscosity == 0) break;
            l2 = log2_fixed(u) + log2_fixed({36'd0, shadow_cfg.reference_height})
                 - log2_fixed({32'd0, shadow_cfg.kinematic_viscosity}) - scale_off;
            lnx = (l2 * longint'(LN2_Q30) + (64'sd1 <<< 29)) >>> 30;
            f = clamp((lnx * 65536) / kap + b24, -FSAT, FSAT);
            fp = clamp(((lnx + (64'sd1 <<< LOG_FRAC)) * 65536) / kap + b24,
                       -FSAT, FSAT);
            if (fp == 0) break;
            p = (u * f + (64'sd1 <<< 23)) >>> 24;
            num = p - target;
            stp = clamp((num * (64'sd1 <<< 24)) / fp, -STEP_SAT, STEP_SAT);
            u = clamp(u - stp, 0, 64'sh0_FFFF_FFFF);
            steps++;
            if (stp <= tol && stp >= -tol) begin
                conv = 1'b1;
                break;
            end
        end
        r.friction_velocity = u[31:0];
        r.surface_flux_out  = it.surface_flux_in;
        r.surface_temp_out  = it.surface_temp_in;
        r.steps_taken       = steps[4:0];
        r.converged         = conv;
        return r;
    endfunction

    // result side: random stalls, long hold-off on request, in-order compare
    initial begin
        int      n;
        result_t got, want;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off_req) begin
                n = 30000;
                hold_off_req = 1'b0;
            end else begin
                n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            got = result_t'(m_tdata[84:0]);
            if (expected_results.size() == 0) begin
                $display("%t unexpected result transaction %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.friction_velocity !== want.friction_velocity) begin
                    $display("%t friction_velocity exp %0d act %0d", $time,
                             want.friction_velocity, got.friction_velocity);
                    error_count++;
                end
                if (got.surface_flux_out !== want.surface_flux_out) begin
                    $display("%t surface_flux_out exp %0d act %0d", $time,
                             want.surface_flux_out, got.surface_flux_out);
                    error_count++;
                end
                if (got.surface_temp_out !== want.surface_temp_out) begin
                    $display("%t surface_temp_out exp %0d act %0d", $time,
                             want.surface_temp_out, got.surface_temp_out);
                    error_count++;
                end
                if (got.steps_taken !== want.steps_taken) begin
                    $display("%t steps_taken exp %0d act %0d", $time,
                             want.steps_taken, got.steps_taken);
                    error_count++;
                end
                if (got.converged !== want.converged) begin
                    $display("%t converged exp %0d act %0d", $time,
                             want.converged, got.converged);
                    error_count++;
                end
            end
        end
    end

    task automatic write_config(logic [27:0] h, logic [15:0] k,
                                logic signed [23:0] b, logic [31:0] v);
        cfg_wr_en <= 1'b1; cfg_index <= REG_HEIGHT; cfg_data <= {4'd0, h};
        @(posedge aclk);
        cfg_index <= REG_KAPPA; cfg_data <= {16'd0, k};
        @(posedge aclk);
        cfg_index <= REG_OFFSET; cfg_data <= {8'd0, b};
        @(posedge aclk);
        cfg_index <= REG_VISC; cfg_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        shadow_cfg.reference_height    = h;
        shadow_cfg.von_karman_constant = k;
        shadow_cfg.log_offset          = b;
        shadow_cfg.kinematic_viscosity = v;
    endtask

    task automatic send_sample(logic [31:0] w, logic [25:0] t,
                               logic signed [20:0] fl, bit no_gap = 1'b0);
        item_t it;
        int    gap;
        it.wind_speed = w;
        it.surface_temp_in = t;
        it.surface_flux_in = fl;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, it};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(solve_friction_velocity(it));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_wind();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 32'h0100_0000);
            default: return $urandom_range(32'h0010_0000, 32'h1E00_0000);
        endcase
    endfunction

    task automatic test_directed_fields();
        send_sample(32'd0, 26'd0, 21'sd0);
        send_sample(32'hFFFF_FFFF, 26'h3FF_FFFF, 21'h0F_FFFF);
        send_sample(32'd5 << 24, 26'd300 << 16, -21'sd1048576);
        send_sample(32'd1, 26'h155_5555, 21'sh0A_AAAA);
        send_sample(32'd10 << 24, 26'h2AA_AAAA, 21'sh15_5555);
        send_sample(32'h0199_999A, 26'd1, -21'sd1);
        send_sample(32'h8000_0000, 26'd290 << 16, 21'sd65536);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        write_config(28'd0, 16'd26214, 24'sd360448, 32'd64425);
        send_sample(32'd5 << 24, 26'd12, 21'sd3);
        wait_drained();
        write_config(28'd327680, 16'd26214, 24'sd360448, 32'd0);
        send_sample(32'd5 << 24, 26'd13, 21'sd4);
        wait_drained();
        write_config(28'hFFF_FFFF, 16'd0, -24'sd8388608, 32'hFFFF_FFFF);
        send_sample(32'd3 << 24, 26'd14, 21'sd5);
        send_sample(32'hFFFF_FFFF, 26'd15, 21'sd6);
        wait_drained();
        write_config(28'd1, 16'hFFFF, 24'sh7F_FFFF, 32'd1);
        send_sample(32'd7 << 24, 26'd16, 21'sd7);
        send_sample(32'd0, 26'd17, 21'sd8);
        wait_drained();
        write_config(28'd65536, 16'd1, 24'sd0, 32'd1000);
        send_sample(32'd2 << 24, 26'd18, 21'sd9);
        wait_drained();
        write_config(28'd327680, 16'd26214, 24'sd360448, 32'd64425);
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        repeat (10) send_sample(rand_wind(), 26'($urandom()), 21'($urandom()), 1'b1);
        wait_drained();
    endtask

    task automatic test_sender_pause();
        repeat (3) send_sample(rand_wind(), 26'($urandom()), 21'($urandom()));
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (3) send_sample(rand_wind(), 26'($urandom()), 21'($urandom()));
        wait_drained();
    endtask

    task automatic test_random(int phases, int per_phase);
        logic [27:0] h;
        logic [15:0] k;
        logic [23:0] b;
        logic [31:0] v;
        for (int ph = 0; ph < phases; ph++) begin
            if (ph % 2 == 0) begin
                h = 28'($urandom_range(32'd16384, 32'd6553600));
                k = 16'($urandom_range(32'd20000, 32'd32000));
                b = 24'($urandom_range(32'd200000, 32'd500000));
                v = $urandom_range(32'd10000, 32'd200000);
            end else begin
                h = 28'($urandom());
                k = 16'($urandom());
                b = 24'($urandom());
                v = $urandom();
            end
            write_config(h, k, b, v);
            for (int i = 0; i < per_phase; i++) begin
                send_sample(rand_wind(), 26'($urandom()), 21'($urandom()), (i % 40) < 8);
            end
            wait_drained();
        end
    endtask

    initial begin
        shadow_cfg.reference_height    = 28'd327680;
        shadow_cfg.von_karman_constant = 16'd26214;
        shadow_cfg.log_offset          = 24'sd360448;
        shadow_cfg.kinematic_viscosity = 32'd64425;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_fields();
        test_config_extremes();
        test_backpressure();
        test_sender_pause();
        test_random(10, 100);
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== log_law_friction_velocity_solver_core.f =====
sv/llfv_pkg.sv
sv/llfv_front.sv
sv/llfv_log2.sv
sv/llfv_div.sv
sv/llfv_back.sv
sv/log_law_friction_velocity_solver_core.sv
bench/log_law_friction_velocity_solver_core_tb.sv
